FILE: hw/rtl/v2alu_pkg.sv
package v2alu_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOL_BITS      = 31;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(66);

  typedef enum logic [2:0] {
    FN_ADD       = 3'd0,
    FN_SUB       = 3'd1,
    FN_SCALE     = 3'd2,
    FN_DOT       = 3'd3,
    FN_NORM_SQR  = 3'd4,
    FN_NORM      = 3'd5,
    FN_NORMALIZE = 3'd6,
    FN_APPROX_EQ = 3'd7
  } func_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

endpackage

FILE: hw/rtl/v2alu_in_if.sv
interface v2alu_in_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  func;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] scale_factor;

  modport source (output valid, func, a_x, a_y, b_x, b_y, scale_factor, input ready);
  modport sink   (input valid, func, a_x, a_y, b_x, b_y, scale_factor, output ready);
endinterface

FILE: hw/rtl/v2alu_out_if.sv
interface v2alu_out_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_x;
  logic signed [WORD_BITS-1:0] res_y;
  logic signed [WORD_BITS-1:0] res_scalar;
  logic                        is_equal;
  logic [1:0]                  status;

  modport source (output valid, res_x, res_y, res_scalar, is_equal, status, input ready);
  modport sink   (input valid, res_x, res_y, res_scalar, is_equal, status, output ready);
endinterface

FILE: hw/rtl/v2alu_cfg_if.sv
interface v2alu_cfg_if;
  import v2alu_pkg::*;
  logic                valid;
  logic                ready;
  logic [TOL_BITS-1:0] tolerance;

  modport source (output valid, tolerance, input ready);
  modport sink   (input valid, tolerance, output ready);
endinterface

FILE: hw/rtl/vec2_fixed_point_alu.sv
// 2-D vector ALU, signed fixed point (WORD_BITS word, FRAC_BITS fraction bits).
// in_i carries one item per handshake: func, vectors a and b, scale_factor.
// out_o returns exactly one result item per input item, in order:
// res_x, res_y, res_scalar, is_equal and status (ok, saturated, zero normalize).
// cfg_i writes the tolerance used by approx_equal; write it only while idle.
// Every item runs through the same pipeline: operand select, multiply, sum,
// magnitude, rounding, one square-root bit per stage (WORD_BITS stages) and
// one quotient bit per stage for normalize (FRAC_BITS+1 stages).
// A new item is accepted every cycle unless out_o stalls; the default
// format is Q16.16. The square-root and divider stage chains set the latency.
// When out_o stalls, the whole pipeline holds and in_i.ready drops; the
// output register keeps its item until taken.
// Reset empties the pipeline and loads the tolerance with 66.
module vec2_fixed_point_alu #(
  parameter int WORD_BITS = v2alu_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v2alu_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  v2alu_in_if.sink    in_i,
  v2alu_out_if.source out_o,
  v2alu_cfg_if.sink   cfg_i
);
  import v2alu_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int T   = TOL_BITS;
  localparam int CW  = (W + 1 > T) ? W + 1 : T;
  localparam int EW  = (PW + 1 > 2 * T) ? PW + 1 : 2 * T;
  localparam int QW  = F + W;

  typedef struct packed {
    func_e          func;
    logic [W-1:0]   rx;
    logic [W-1:0]   ry;
    logic [W-1:0]   rs;
    logic           eq;
    logic           sat;
    logic [W-1:0]   ax_mag;
    logic [W-1:0]   ay_mag;
    logic           ax_neg;
    logic           ay_neg;
  } cr_t;

  typedef struct packed {
    cr_t          cr;
    logic [W-1:0] m0a, m0b, m1a, m1b;
    logic         n0, n1;
    logic         near;
  } s1_t;

  typedef struct packed {
    cr_t           cr;
    logic [PW-1:0] p0, p1;
    logic          n0, n1;
    logic          near;
  } s2_t;

  typedef struct packed {
    cr_t           cr;
    logic [PW+1:0] sum;
    logic [PW-1:0] p0, p1;
    logic          n0, n1;
    logic [PW-1:0] rad;
  } s3_t;

  typedef struct packed {
    cr_t           cr;
    logic [PW:0]   sum_mag;
    logic          sum_neg;
    logic [PW-1:0] p0, p1;
    logic          n0, n1;
    logic [PW-1:0] rad;
  } s4_t;

  typedef struct packed {
    cr_t           cr;
    logic [PW-1:0] rad;
    logic [W+1:0]  rem;
    logic [W-1:0]  root;
  } sq_t;

  typedef struct packed {
    cr_t          cr;
    logic         zero;
    logic [W-1:0] den;
    logic [W:0]   remx, remy;
    logic [F:0]   qx, qy;
  } dv_t;

  function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  function automatic logic [W:0] sat_sum(logic [W:0] v);
    if (v[W] != v[W-1]) begin
      return {1'b1, v[W], {(W-1){~v[W]}}};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] round_sat(logic neg, logic [PW:0] mag);
    logic [PW:0]  r;
    logic [PW:0]  lim;
    logic [W-1:0] m;
    r   = (mag + ((PW+1)'(1) << (F - 1))) >> F;
    lim = neg ? ((PW+1)'(1) << (W - 1)) : (((PW+1)'(1) << (W - 1)) - (PW+1)'(1));
    m   = r[W-1:0];
    if (r > lim) begin
      return {1'b1, neg, {(W-1){~neg}}};
    end
    return {1'b0, neg ? (~m + W'(1)) : m};
  endfunction

  function automatic logic [W:0] quot_sat(logic neg, logic [F:0] q);
    logic [QW-1:0] e;
    logic [QW-1:0] lim;
    logic [W-1:0]  m;
    e   = QW'(q);
    lim = neg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    m   = e[W-1:0];
    if (e > lim) begin
      return {1'b1, neg, {(W-1){~neg}}};
    end
    return {1'b0, neg ? (~m + W'(1)) : m};
  endfunction

  logic            adv;
  logic [T-1:0]    tol_q;
  logic [2*T-1:0]  tsq_q;
  logic            v1_q, v2_q, v3_q, v4_q;
  s1_t             s1_d, s1_q;
  s2_t             s2_d, s2_q;
  s3_t             s3_d, s3_q;
  s4_t             s4_d, s4_q;
  logic            sq_v_q [W+1];
  sq_t             sq_q   [W+1];
  sq_t             sq0_d;
  logic            dv_v_q [F+2];
  dv_t             dv_q   [F+2];
  dv_t             dv0_d;
  logic            out_valid_q;
  logic [W-1:0]    res_x_d, res_y_d, res_s_d;
  logic [W-1:0]    res_x_q, res_y_q, res_s_q;
  logic            eq_q;
  logic [1:0]      st_d, st_q;

  assign adv         = !out_valid_q || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.tolerance;
    end
  end

  always_ff @(posedge clk_i) begin
    tsq_q <= (2*T)'(tol_q) * (2*T)'(tol_q);
  end

  // operand select, add/sub, distance check
  always_comb begin
    logic [W-1:0] ax, ay, bx, by, sf, sfm;
    logic [W:0]   sx, sy, dx, dy, dxm, dym, rsx, rsy;
    logic         sfn;
    ax  = in_i.a_x;
    ay  = in_i.a_y;
    bx  = in_i.b_x;
    by  = in_i.b_y;
    sf  = in_i.scale_factor;
    sfn = sf[W-1];
    sfm = mag_of(sf);
    sx  = {ax[W-1], ax} + {bx[W-1], bx};
    sy  = {ay[W-1], ay} + {by[W-1], by};
    dx  = {ax[W-1], ax} - {bx[W-1], bx};
    dy  = {ay[W-1], ay} - {by[W-1], by};
    dxm = dx[W] ? (~dx + (W+1)'(1)) : dx;
    dym = dy[W] ? (~dy + (W+1)'(1)) : dy;
    s1_d           = '0;
    s1_d.cr.func   = func_e'(in_i.func);
    s1_d.cr.ax_neg = ax[W-1];
    s1_d.cr.ay_neg = ay[W-1];
    s1_d.cr.ax_mag = mag_of(ax);
    s1_d.cr.ay_mag = mag_of(ay);
    s1_d.near      = (CW'(dxm) < CW'(tol_q)) && (CW'(dym) < CW'(tol_q));
    rsx = '0;
    rsy = '0;
    if (s1_d.cr.func == FN_ADD) begin
      rsx = sat_sum(sx);
      rsy = sat_sum(sy);
    end else if (s1_d.cr.func == FN_SUB) begin
      rsx = sat_sum(dx);
      rsy = sat_sum(dy);
    end
    s1_d.cr.rx  = rsx[W-1:0];
    s1_d.cr.ry  = rsy[W-1:0];
    s1_d.cr.sat = rsx[W] | rsy[W];
    case (s1_d.cr.func)
      FN_SCALE: begin
        s1_d.m0a = sfm;            s1_d.m0b = s1_d.cr.ax_mag;
        s1_d.m1a = sfm;            s1_d.m1b = s1_d.cr.ay_mag;
        s1_d.n0  = sfn ^ ax[W-1];  s1_d.n1  = sfn ^ ay[W-1];
      end
      FN_DOT: begin
        s1_d.m0a = s1_d.cr.ax_mag; s1_d.m0b = mag_of(bx);
        s1_d.m1a = s1_d.cr.ay_mag; s1_d.m1b = mag_of(by);
        s1_d.n0  = ax[W-1] ^ bx[W-1];
        s1_d.n1  = ay[W-1] ^ by[W-1];
      end
      FN_APPROX_EQ: begin
        s1_d.m0a = dxm[W-1:0];     s1_d.m0b = dxm[W-1:0];
        s1_d.m1a = dym[W-1:0];     s1_d.m1b = dym[W-1:0];
      end
      default: begin
        s1_d.m0a = s1_d.cr.ax_mag; s1_d.m0b = s1_d.cr.ax_mag;
        s1_d.m1a = s1_d.cr.ay_mag; s1_d.m1b = s1_d.cr.ay_mag;
      end
    endcase
  end

  always_comb begin
    s2_d      = '0;
    s2_d.cr   = s1_q.cr;
    s2_d.p0   = PW'(s1_q.m0a) * PW'(s1_q.m0b);
    s2_d.p1   = PW'(s1_q.m1a) * PW'(s1_q.m1b);
    s2_d.n0   = s1_q.n0;
    s2_d.n1   = s1_q.n1;
    s2_d.near = s1_q.near;
  end

  always_comb begin
    logic [PW+1:0] v0, v1;
    logic [PW:0]   ps;
    v0 = s2_q.n0 ? (~(PW+2)'(s2_q.p0) + (PW+2)'(1)) : (PW+2)'(s2_q.p0);
    v1 = s2_q.n1 ? (~(PW+2)'(s2_q.p1) + (PW+2)'(1)) : (PW+2)'(s2_q.p1);
    ps = (PW+1)'(s2_q.p0) + (PW+1)'(s2_q.p1);
    s3_d       = '0;
    s3_d.cr    = s2_q.cr;
    s3_d.sum   = v0 + v1;
    s3_d.p0    = s2_q.p0;
    s3_d.p1    = s2_q.p1;
    s3_d.n0    = s2_q.n0;
    s3_d.n1    = s2_q.n1;
    s3_d.rad   = ps[PW-1:0];
    s3_d.cr.eq = (s2_q.cr.func == FN_APPROX_EQ) && s2_q.near && (EW'(ps) < EW'(tsq_q));
  end

  always_comb begin
    logic [PW+1:0] ng;
    ng = ~s3_q.sum + (PW+2)'(1);
    s4_d         = '0;
    s4_d.cr      = s3_q.cr;
    s4_d.sum_neg = s3_q.sum[PW+1];
    s4_d.sum_mag = s3_q.sum[PW+1] ? ng[PW:0] : s3_q.sum[PW:0];
    s4_d.p0      = s3_q.p0;
    s4_d.p1      = s3_q.p1;
    s4_d.n0      = s3_q.n0;
    s4_d.n1      = s3_q.n1;
    s4_d.rad     = s3_q.rad;
  end

  // rounding of products and sums
  always_comb begin
    logic [W:0] r0, r1, rsum;
    r0   = round_sat(s4_q.n0, {1'b0, s4_q.p0});
    r1   = round_sat(s4_q.n1, {1'b0, s4_q.p1});
    rsum = round_sat(s4_q.sum_neg, s4_q.sum_mag);
    sq0_d     = '0;
    sq0_d.cr  = s4_q.cr;
    sq0_d.rad = s4_q.rad;
    case (s4_q.cr.func)
      FN_SCALE: begin
        sq0_d.cr.rx  = r0[W-1:0];
        sq0_d.cr.ry  = r1[W-1:0];
        sq0_d.cr.sat = r0[W] | r1[W];
      end
      FN_DOT, FN_NORM_SQR: begin
        sq0_d.cr.rs  = rsum[W-1:0];
        sq0_d.cr.sat = rsum[W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_i.valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      sq_v_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      s3_q    <= s3_d;
      s4_q    <= s4_d;
      sq_q[0] <= sq0_d;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    sq_t          nx;
    logic [W+1:0] rn, tr;
    always_comb begin
      rn = {sq_q[k].rem[W-1:0], sq_q[k].rad[PW-1:PW-2]};
      tr = {sq_q[k].root, 2'b01};
      nx     = sq_q[k];
      nx.rad = {sq_q[k].rad[PW-3:0], 2'b00};
      if (rn >= tr) begin
        nx.rem  = rn - tr;
        nx.root = {sq_q[k].root[W-2:0], 1'b1};
      end else begin
        nx.rem  = rn;
        nx.root = {sq_q[k].root[W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k+1] <= nx;
      end
    end
  end

  always_comb begin
    logic [W-1:0] rt;
    rt = sq_q[W].root;
    dv0_d      = '0;
    dv0_d.cr   = sq_q[W].cr;
    dv0_d.zero = (rt == '0);
    dv0_d.den  = rt;
    dv0_d.remx = {2'b00, sq_q[W].cr.ax_mag[W-1:1]};
    dv0_d.remy = {2'b00, sq_q[W].cr.ay_mag[W-1:1]};
    if (sq_q[W].cr.func == FN_NORM) begin
      dv0_d.cr.rs  = rt[W-1] ? {1'b0, {(W-1){1'b1}}} : rt;
      dv0_d.cr.sat = rt[W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= sq_v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv0_d;
    end
  end

  // restoring divide for normalize, one quotient bit per stage
  for (genvar k = 0; k <= F; k++) begin : g_div
    dv_t        nx;
    logic [W:0] rnx, rny, dd;
    logic       bx, by;
    always_comb begin
      bx  = (k == 0) ? dv_q[k].cr.ax_mag[0] : 1'b0;
      by  = (k == 0) ? dv_q[k].cr.ay_mag[0] : 1'b0;
      rnx = {dv_q[k].remx[W-1:0], bx};
      rny = {dv_q[k].remy[W-1:0], by};
      dd  = {1'b0, dv_q[k].den};
      nx  = dv_q[k];
      if (rnx >= dd) begin
        nx.remx = rnx - dd;
        nx.qx   = {dv_q[k].qx[F-1:0], 1'b1};
      end else begin
        nx.remx = rnx;
        nx.qx   = {dv_q[k].qx[F-1:0], 1'b0};
      end
      if (rny >= dd) begin
        nx.remy = rny - dd;
        nx.qy   = {dv_q[k].qy[F-1:0], 1'b1};
      end else begin
        nx.remy = rny;
        nx.qy   = {dv_q[k].qy[F-1:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k+1] <= nx;
      end
    end
  end

  always_comb begin
    logic [W:0] qx, qy;
    logic       sat;
    qx      = quot_sat(dv_q[F+1].cr.ax_neg, dv_q[F+1].qx);
    qy      = quot_sat(dv_q[F+1].cr.ay_neg, dv_q[F+1].qy);
    res_x_d = dv_q[F+1].cr.rx;
    res_y_d = dv_q[F+1].cr.ry;
    res_s_d = dv_q[F+1].cr.rs;
    sat     = dv_q[F+1].cr.sat;
    st_d    = ST_OK;
    if (dv_q[F+1].cr.func == FN_NORMALIZE) begin
      if (dv_q[F+1].zero) begin
        res_x_d = '0;
        res_y_d = '0;
        sat     = 1'b0;
        st_d    = ST_ZERO;
      end else begin
        res_x_d = qx[W-1:0];
        res_y_d = qy[W-1:0];
        sat     = qx[W] | qy[W];
      end
    end
    if (sat) begin
      st_d = ST_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v_q[F+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_x_q <= res_x_d;
      res_y_q <= res_y_d;
      res_s_q <= res_s_d;
      eq_q    <= dv_q[F+1].cr.eq;
      st_q    <= st_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.res_x      = res_x_q;
  assign out_o.res_y      = res_y_q;
  assign out_o.res_scalar = res_s_q;
  assign out_o.is_equal   = eq_q;
  assign out_o.status     = st_q;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import v2alu_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = WB + FB + 8;

  typedef struct packed {
    logic signed [WB-1:0] res_x;
    logic signed [WB-1:0] res_y;
    logic signed [WB-1:0] res_scalar;
    logic                 is_equal;
    logic [1:0]           status;
  } alu_res_t;

  logic clk_i;
  logic rst_ni;

  v2alu_in_if  #(.WORD_BITS(WB)) in_if ();
  v2alu_out_if #(.WORD_BITS(WB)) out_if ();
  v2alu_cfg_if                   cfg_if ();

  vec2_fixed_point_alu #(.WORD_BITS(WB), .FRAC_BITS(FB)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  alu_res_t              expected_q[$];
  logic [TOL_BITS-1:0]   tol_model;
  int                    n_err = 0;
  int                    n_res = 0;
  int                    n_items;
  bit                    idle_on;
  int                    hold_cycles = 0;
  int                    long_req = 0;
  int                    long_seen = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [WB-1:0] sat_word(input logic signed [127:0] v,
                                                    inout bit sat);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (WB - 1)) - 1;
    lo = -(128'sd1 <<< (WB - 1));
    if (v > hi) begin
      sat = 1;
      return hi[WB-1:0];
    end
    if (v < lo) begin
      sat = 1;
      return lo[WB-1:0];
    end
    return v[WB-1:0];
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [127:0] round_frac(input logic signed [127:0] v);
    logic [127:0] m;
    m = v < 0 ? -v : v;
    m = (m + (128'd1 << (FB - 1))) >> FB;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic alu_res_t alu_predict(input func_e fn, input logic signed [WB-1:0] ax,
                                           input logic signed [WB-1:0] ay,
                                           input logic signed [WB-1:0] bx,
                                           input logic signed [WB-1:0] by,
                                           input logic signed [WB-1:0] sf);
    alu_res_t r;
    bit sat;
    logic signed [127:0] xa, ya, xb, yb, s, dx, dy;
    logic [127:0] n, t2;
    r = '0;
    sat = 0;
    xa = ax; ya = ay; xb = bx; yb = by; s = sf;
    case (fn)
      FN_ADD: begin
        r.res_x = sat_word(xa + xb, sat);
        r.res_y = sat_word(ya + yb, sat);
      end
      FN_SUB: begin
        r.res_x = sat_word(xa - xb, sat);
        r.res_y = sat_word(ya - yb, sat);
      end
      FN_SCALE: begin
        r.res_x = sat_word(round_frac(s * xa), sat);
        r.res_y = sat_word(round_frac(s * ya), sat);
      end
      FN_DOT: r.res_scalar = sat_word(round_frac(xa * xb + ya * yb), sat);
      FN_NORM_SQR: r.res_scalar = sat_word(round_frac(xa * xa + ya * ya), sat);
      FN_NORM: r.res_scalar = sat_word($signed(isqrt(xa * xa + ya * ya)), sat);
      FN_NORMALIZE: begin
        n = isqrt(xa * xa + ya * ya);
        if (n == 0) begin
          r.status = ST_ZERO;
        end else begin
          r.res_x = sat_word((xa <<< FB) / $signed(n), sat);
          r.res_y = sat_word((ya <<< FB) / $signed(n), sat);
        end
      end
      default: begin
        dx = xa - xb;
        dy = ya - yb;
        t2 = tol_model;
        r.is_equal = (dx * dx + dy * dy) < t2 * t2;
      end
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  task automatic send_op(input func_e fn, input logic signed [WB-1:0] ax,
                         input logic signed [WB-1:0] ay, input logic signed [WB-1:0] bx,
                         input logic signed [WB-1:0] by, input logic signed [WB-1:0] sf);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= fn;
    in_if.a_x          <= ax;
    in_if.a_y          <= ay;
    in_if.b_x          <= bx;
    in_if.b_y          <= by;
    in_if.scale_factor <= sf;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(alu_predict(fn, ax, ay, bx, by, sf));
    n_items++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TOL_BITS-1:0] tol);
    drain_results();
    cfg_if.valid     <= 1'b1;
    cfg_if.tolerance <= tol;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    tol_model = tol;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [WB-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $signed({1'b0, {(WB-1){1'b1}}});
      1: return $signed({1'b1, {(WB-1){1'b0}}});
      2: return $signed(WB'($urandom_range(0, 1 << 20)) - (WB'(1) << 19));
      3: return $signed(WB'($urandom_range(0, 8)));
      default: return $signed(WB'($urandom));
    endcase
  endfunction

  always @(posedge clk_i) begin
    alu_res_t got;
    alu_res_t exp_r;
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.res_x, out_if.res_y, out_if.res_scalar, out_if.is_equal,
              out_if.status};
      n_res++;
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if (long_seen != long_req) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= 3 * LATENCY;
      long_seen    <= long_req;
    end else if (idle_on && out_if.ready && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= $urandom_range(0, 16);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic test_directed();
    logic signed [WB-1:0] mx, mn, one;
    mx  = $signed({1'b0, {(WB-1){1'b1}}});
    mn  = $signed({1'b1, {(WB-1){1'b0}}});
    one = $signed(WB'(1) << FB);
    send_op(FN_ADD, mx, mn, one, mn, 0);
    send_op(FN_SUB, mn, mx, one, -one, 0);
    send_op(FN_SCALE, mx, mn, 0, 0, mn);
    send_op(FN_SCALE, one, -one, 0, 0, one >>> 1);
    send_op(FN_SCALE, 1, -1, 0, 0, one >>> 1);
    send_op(FN_DOT, mx, mx, mx, mx, 0);
    send_op(FN_DOT, one, 3, -one, 5, 0);
    send_op(FN_NORM_SQR, mn, mn, 0, 0, 0);
    send_op(FN_NORM_SQR, 0, 0, 0, 0, 0);
    send_op(FN_NORM, mn, mn, 0, 0, 0);
    send_op(FN_NORM, 3 * one, 4 * one, 0, 0, 0);
    send_op(FN_NORMALIZE, 0, 0, 5, 5, 5);
    send_op(FN_NORMALIZE, 1, 0, 0, 0, 0);
    send_op(FN_NORMALIZE, mn, mn, 0, 0, 0);
    send_op(FN_NORMALIZE, -3 * one, 4 * one, 0, 0, 0);
    send_op(FN_APPROX_EQ, one, one, one + 40, one - 40, 0);
    send_op(FN_APPROX_EQ, one, one, one + 65, one, 0);
    send_op(FN_APPROX_EQ, one, one, one + 66, one, 0);
    send_op(FN_APPROX_EQ, mx, mn, mn, mx, 0);
    send_op(FN_APPROX_EQ, 7, 7, 7, 7, 0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_op(func_e'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word());
  endtask

  task automatic test_tolerance_sweep();
    logic [TOL_BITS-1:0] tols[4];
    logic signed [WB-1:0] ax, ay;
    tols = '{'0, {TOL_BITS{1'b1}}, TOL_BITS'(1), TOL_BITS'($urandom_range(1, 1 << 20))};
    foreach (tols[t]) begin
      write_tolerance(tols[t]);
      for (int i = 0; i < 15; i++) begin
        ax = rand_word();
        ay = rand_word();
        send_op(FN_APPROX_EQ, ax, ay, ax + $signed(WB'($urandom_range(0, 1 << 21))) - (1 << 20),
                ay + $signed(WB'($urandom_range(0, 64))) - 32, 0);
      end
    end
    write_tolerance(TOL_RESET);
  endtask

  task automatic test_backpressure();
    long_req++;
    test_random(2 * LATENCY);
    drain_results();
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = FN_ADD;
    in_if.a_x          = '0;
    in_if.a_y          = '0;
    in_if.b_x          = '0;
    in_if.b_y          = '0;
    in_if.scale_factor = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.tolerance   = '0;
    tol_model          = TOL_RESET;
    n_items            = 0;
    idle_on            = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tolerance_sweep();
    test_backpressure();
    test_random(200);
    idle_on = 1'b0;
    test_random(60);
    drain_results();
    $display("covered %0d items, %0d results, all eight ops, tolerance sweep, stalls",
             n_items, n_res);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors, %0d left over", n_err, expected_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
